// ===== src/drrs_pkg.sv =====
// shared types, codes and helpers for the digit rotate range sum store
package drrs_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned LEN_W   = 11;

  // marks a position that was never loaded
  localparam logic [DIGIT_W-1:0] EMPTY_CODE = 4'hF;
  localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_ROTATE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_OUT
  } state_e;

  // reduce a 4-bit value to a decimal digit
  function automatic logic [DIGIT_W-1:0] dec_digit(input logic [DIGIT_W-1:0] v);
    dec_digit = (v >= RADIX) ? v - RADIX : v;
  endfunction

  // add two decimal digits mod 10
  function automatic logic [DIGIT_W-1:0] dec_add(input logic [DIGIT_W-1:0] x,
                                                 input logic [DIGIT_W-1:0] y);
    logic [DIGIT_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    dec_add = (s >= {1'b0, RADIX}) ? DIGIT_W'(s - {1'b0, RADIX}) : s[DIGIT_W-1:0];
  endfunction

endpackage

// ===== src/drrs_ram.sv =====
// generic simple dual port ram with registered read
module drrs_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/drrs_core.sv =====
// sequencer and shared digit adder that sweeps the digit store
module drrs_core #(
  parameter int unsigned MAX_POSITIONS = 1024,
  parameter int unsigned AW            = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [drrs_pkg::LEN_W-1:0]     len_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  drrs_pkg::action_e              action_i,
  input  logic [drrs_pkg::POS_W-1:0]     first_i,
  input  logic [drrs_pkg::POS_W-1:0]     last_i,
  input  logic [drrs_pkg::DIGIT_W-1:0]   digit_i,
  input  logic [drrs_pkg::DIGIT_W-1:0]   amount_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [drrs_pkg::SUM_W-1:0]     digit_sum_o,
  output logic                           ram_we_o,
  output logic [AW-1:0]                  ram_waddr_o,
  output logic [drrs_pkg::DIGIT_W-1:0]   ram_wdata_o,
  output logic [AW-1:0]                  ram_raddr_o,
  input  logic [drrs_pkg::DIGIT_W-1:0]   ram_rdata_i
);
  import drrs_pkg::*;

  localparam int unsigned CW = (AW + 2 > POS_W) ? AW + 2 : POS_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_POSITIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        end_q, end_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        pend_addr_q, pend_addr_d;
  logic [DIGIT_W-1:0]   amt_q, amt_d;
  logic [SUM_W-1:0]     acc_q, acc_d;
  logic                 out_valid_q, out_valid_d;
  logic [SUM_W-1:0]     out_data_q, out_data_d;

  logic [CW-1:0]        len_raw, len_c, first_c, last_c, a_c, b_c;
  logic [DIGIT_W-1:0]   amt_in;

  // clip the range to the positions in use
  always_comb begin
    len_raw = CW'(len_i);
    if (len_raw == '0) begin
      len_c = CW'(1);
    end else if (len_raw > MAX_C) begin
      len_c = MAX_C;
    end else begin
      len_c = len_raw;
    end
    first_c = CW'(first_i);
    last_c  = CW'(last_i);
    a_c     = (first_c == '0) ? CW'(1) : first_c;
    b_c     = (last_c > len_c) ? len_c : last_c;
    amt_in  = dec_digit(amount_i);
  end

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    end_q       <= end_d;
    pend_addr_q <= pend_addr_d;
    amt_q       <= amt_d;
    acc_q       <= acc_d;
    out_data_q  <= out_data_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    amt_d       = amt_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = pend_addr_q;
    ram_wdata_o = EMPTY_CODE;
    ram_raddr_o = ptr_q;

    // retire the digit read last cycle through the shared adder
    if (pend_q && ram_rdata_i != EMPTY_CODE) begin
      acc_d = acc_q + SUM_W'(ram_rdata_i);
      if (act_q == ACT_ROTATE) begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pend_addr_q;
        ram_wdata_o = dec_add(ram_rdata_i, amt_q);
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q;
        ram_wdata_o = EMPTY_CODE;
        ptr_d       = ptr_q + 1'b1;
        if (ptr_q == LAST_ADDR) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d   = action_i;
          acc_d   = '0;
          amt_d   = amt_in;
          ptr_d   = AW'(a_c - CW'(1));
          end_d   = AW'(b_c - CW'(1));
          state_d = ST_OUT;
          case (action_i)
            ACT_LOAD: begin
              if (first_c != '0 && first_c <= len_c) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = AW'(first_c - CW'(1));
                ram_wdata_o = dec_digit(digit_i);
              end
            end
            ACT_QUERY: begin
              if (a_c <= b_c) begin
                state_d = ST_SCAN;
              end
            end
            ACT_ROTATE: begin
              if (a_c <= b_c && amt_in != '0) begin
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ram_raddr_o = ptr_q;
        pend_d      = 1'b1;
        pend_addr_d = ptr_q;
        ptr_d       = ptr_q + 1'b1;
        if (ptr_q == end_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = (act_q == ACT_QUERY) ? acc_q : '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign digit_sum_o = out_data_q;

endmodule

// ===== src/digit_rotate_range_sum_tree.sv =====
// top level: config register, stream ports, sequencer and digit store
//
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------
//  s_axis    | tvalid / tready  | action, first, last, digit, amount
//  m_axis    | tvalid / tready  | digit_sum
//  apb       | psel / penable   | length_in_use at byte address 0
//
// a load, an unused action, an empty range or a rotate by zero goes from
// the beat to the output state, which loads the result register; a query or
// rotate sweeps its range in the scan and flush states through the single
// read/write port pair of the digit store and the one shared digit adder.
// after reset a clearing pass empties all MAX_POSITIONS positions, and no
// input beat is taken meanwhile. one item is in work at a time; a finished
// result waits in the output register while the next beat is taken.
module digit_rotate_range_sum_tree #(
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // action[1:0], first[12:2], last[23:13], digit[27:24], amount[31:28]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // digit_sum[13:0], zero fill[15:14]
  output logic [15:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import drrs_pkg::*;

  localparam int unsigned AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int unsigned RAM_DEPTH = 1 << AW;

  logic [LEN_W-1:0]   len_q;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [DIGIT_W-1:0] ram_wdata, ram_rdata;
  logic [SUM_W-1:0]   digit_sum;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1024);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      len_q <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - LEN_W){1'b0}}, len_q};

  drrs_core #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .AW           (AW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .len_i      (len_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .action_i   (action_e'(s_axis_tdata_i[1:0])),
    .first_i    (s_axis_tdata_i[12:2]),
    .last_i     (s_axis_tdata_i[23:13]),
    .digit_i    (s_axis_tdata_i[27:24]),
    .amount_i   (s_axis_tdata_i[31:28]),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .digit_sum_o(digit_sum),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  drrs_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tdata_o = {2'b00, digit_sum};

endmodule
